/* design/rdse_pkg.sv */
// Shared constants, codes and digit character lookup for the radix digit emitter.
package rdse_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int IN_VALUE_W     = 64;
  localparam int ACTION_W       = 3;
  localparam int CHAR_W         = 7;
  localparam int DIGIT_W        = 4;

  // action codes on the input beat
  localparam logic [ACTION_W-1:0] ACT_UDEC = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_OCT  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_HEXL = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_HEXU = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SDEC = 3'd4;

  typedef enum logic [1:0] {
    RDX_DEC,
    RDX_OCT,
    RDX_HEX
  } radix_t;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;

  // digit value to ASCII
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] ofs;
    if (d < 4'd10) begin
      base = CHAR_ZERO;
      ofs  = {3'b000, d};
    end else begin
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      ofs  = {3'b000, d - 4'd10};
    end
    return base + ofs;
  endfunction

endpackage

/* design/radix_digit_string_emitter.sv */
// Top level: serial binary to ASCII digit converter, decimal, octal and hex.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | in_value, in_action                     | start && !busy takes the beat
//  result  | out_digit_char, out_last                | out_valid, one cycle, no stall
//
// Busy: an accepted beat holds busy through the bit-serial conversion loop and
// then the output scan; a new beat is taken only once busy has dropped. The
// conversion loop shifts one value bit into the digit row per cycle; the output
// scan consumes one digit slot per cycle, skipping leading zeros and strobing
// the rest MS digit first. The last digit strobes in the first idle cycle.
// Reset: synchronous, active low; returns to idle with no strobe pending.
// Stalls: the receiver cannot stall, so nothing backs up; busy alone gates start.
module radix_digit_string_emitter #(
  parameter int VALUE_BITS = rdse_pkg::VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rdse_pkg::IN_VALUE_W-1:0] in_value,
  input  logic [rdse_pkg::ACTION_W-1:0]   in_action,
  output logic                           out_valid,
  output logic [rdse_pkg::CHAR_W-1:0]     out_digit_char,
  output logic                           out_last
);
  import rdse_pkg::*;

  // Digit row depth: enough decimal digits for 2^VALUE_BITS-1, or octal digits.
  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int SLOTS      = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN
  } state_t;

  state_t                  state_r, state_nxt;
  radix_t                  radix_r, radix_nxt;
  logic                    upper_r, upper_nxt;
  logic [VALUE_BITS-1:0]   work_r, work_nxt;
  logic [BIT_CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0]      store_r   [SLOTS];
  logic [DIGIT_W-1:0]      store_nxt [SLOTS];
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]       out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  // conversion step: per-slot adjust and shift, carries ripple one slot per bit
  logic [DIGIT_W-1:0]      conv_slot [SLOTS];
  logic [SLOTS-1:0]        carry;

  logic [VALUE_BITS-1:0]   in_v;
  logic [DIGIT_W-1:0]      top_digit;

  assign in_v      = in_value[VALUE_BITS-1:0];
  assign top_digit = store_r[SLOTS-1];

  always_comb begin
    logic [DIGIT_W-1:0] adj;
    logic               cin;
    for (int i = 0; i < SLOTS; i++) begin
      // double dabble: bump digits of five or more before the shift
      adj = store_r[i];
      if (radix_r == RDX_DEC && store_r[i] >= 4'd5) begin
        adj = store_r[i] + 4'd3;
      end
      cin = (i == 0) ? work_r[VALUE_BITS-1] : carry[(i == 0) ? 0 : i-1];
      if (radix_r == RDX_OCT) begin
        carry[i]     = adj[2];
        conv_slot[i] = {1'b0, adj[1:0], cin};
      end else begin
        carry[i]     = adj[3];
        conv_slot[i] = {adj[2:0], cin};
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    radix_nxt     = radix_r;
    upper_nxt     = upper_r;
    work_nxt      = work_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    store_nxt     = store_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // decode the action; unused codes fall back to unsigned decimal
          upper_nxt = 1'b0;
          work_nxt  = in_v;
          case (in_action)
            ACT_OCT:  radix_nxt = RDX_OCT;
            ACT_HEXL: radix_nxt = RDX_HEX;
            ACT_HEXU: begin
              radix_nxt = RDX_HEX;
              upper_nxt = 1'b1;
            end
            ACT_SDEC: begin
              radix_nxt = RDX_DEC;
              // magnitude only; the most negative value wraps to 2^(n-1)
              if (in_v[VALUE_BITS-1]) begin
                work_nxt = '0 - in_v;
              end
            end
            default:  radix_nxt = RDX_DEC;
          endcase
          for (int i = 0; i < SLOTS; i++) begin
            store_nxt[i] = '0;
          end
          bit_cnt_nxt = BIT_CNT_W'(VALUE_BITS - 1);
          state_nxt   = ST_CONV;
        end
      end

      ST_CONV: begin
        store_nxt = conv_slot;
        work_nxt  = {work_r[VALUE_BITS-2:0], 1'b0};
        if (bit_cnt_r == '0) begin
          cnt_nxt   = CNT_W'(SLOTS);
          state_nxt = ST_SCAN;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 1'b1;
        end
      end

      ST_SCAN: begin
        // walk the row MS slot first; leading zeros drop out silently
        for (int i = SLOTS - 1; i > 0; i--) begin
          store_nxt[i] = store_r[i-1];
        end
        store_nxt[0] = '0;
        cnt_nxt      = cnt_r - 1'b1;
        if (top_digit != '0 || cnt_r == CNT_W'(1) || out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(top_digit, upper_r);
          out_last_nxt  = (cnt_r == CNT_W'(1));
        end
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      cnt_r       <= cnt_nxt;
    end
    radix_r    <= radix_nxt;
    upper_r    <= upper_nxt;
    work_r     <= work_nxt;
    store_r    <= store_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

  // final digit strobes in the cycle the block returns to idle
  a_last_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> state_r == ST_IDLE)
    else $error("last digit strobed outside idle");

  // inner digits only appear while scanning
  a_mid_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> state_r == ST_SCAN)
    else $error("digit strobed outside scan");

  // once the first digit is out, digits follow each cycle until the last
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |=> out_valid_r)
    else $error("gap in digit string");

  // a new beat never starts with a strobe in its first cycle
  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> !out_valid_r && state_r == ST_CONV)
    else $error("unexpected strobe after accept");

  // scan never runs with an empty slot count
  a_scan_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> cnt_r != '0)
    else $error("scan with zero slot count");

endmodule
